@@ src/length_prefixed_frame_checker_assert.svh @@
// assertion macros used by the frame checker queue module
`ifndef LENGTH_PREFIXED_FRAME_CHECKER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_CHECKER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define LPFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define LPFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/lpfc_pkg.sv @@
// types and constants of the length prefixed frame checker
package lpfc_pkg;

  localparam logic [7:0]  CHR_TAIL   = 8'h24;
  localparam logic [7:0]  CHR_E      = 8'h45;
  localparam logic [7:0]  CHR_P      = 8'h50;
  localparam logic [7:0]  CHR_N      = 8'h4E;
  localparam logic [7:0]  CHR_H      = 8'h48;
  localparam logic [7:0]  CHR_PLUS   = 8'h2B;
  localparam logic [7:0]  CHR_MINUS  = 8'h2D;
  localparam logic [7:0]  CHR_ZERO   = 8'h30;
  localparam logic [7:0]  CHR_NINE   = 8'h39;
  localparam logic [7:0]  CHR_SPACE  = 8'h20;
  localparam logic [7:0]  CHR_TAB    = 8'h09;
  localparam logic [7:0]  CHR_CR     = 8'h0D;

  localparam logic [31:0] POS_MAX    = 32'hFFFF_FFFF;
  localparam logic [31:0] HDR_LEN_M0 = 32'd6;
  localparam logic [31:0] HDR_LEN_M1 = 32'd8;
  localparam logic [31:0] MIN_LEN_M0 = 32'd7;
  localparam logic [31:0] MIN_LEN_M1 = 32'd9;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [2:0] {
    VRD_OK           = 3'd0,
    VRD_SHORT        = 3'd1,
    VRD_BAD_HDR      = 3'd2,
    VRD_LEN_MISMATCH = 3'd3,
    VRD_BAD_TAIL     = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } digit_phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    item_kind_t item_kind;
    logic [7:0] payload_byte;
    verdict_t   verdict;
    logic       frame_end;
  } out_beat_t;

  // one accepted input byte as the back end sees it
  typedef struct packed {
    logic       pay_vld;
    logic [7:0] pay_byte;
    logic       vrd_vld;
    verdict_t   verdict;
  } step_rec_t;

  // head of the queue towards the back end
  typedef struct packed {
    logic      vld;
    step_rec_t rec;
  } queue_head_t;

endpackage

@@ src/lpfc_fifo.sv @@
// short queue of step records between front and back end
`include "length_prefixed_frame_checker_assert.svh"

module lpfc_fifo import lpfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  step_rec_t   push_rec,
  output logic        full,
  input  logic        pop,
  output queue_head_t head
);

  step_rec_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic [QUEUE_AW:0]   count_nxt;

  assign full     = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head.vld = (count_r != '0);
  assign head.rec = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  `LPFC_ASSERT(a_no_overflow, !(push && full && !pop), "record pushed into a full queue")
  `LPFC_ASSERT(a_no_underflow, !(pop && !head.vld), "record popped from an empty queue")
  `LPFC_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "queue count lost a push")
  `LPFC_ASSERT(a_count_range, count_r <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue count out of range")

endmodule

@@ src/lpfc_front.sv @@
// front end: header check, length field reading, position count, verdict
module lpfc_front import lpfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      frame_mode,
  input  logic      acc,
  input  in_beat_t  beat,
  output logic      push,
  output step_rec_t rec
);

  logic [31:0]  pos_r, pos_nxt;
  logic         hdr_good_r, hdr_good_nxt;
  logic [31:0]  decl_len_r, decl_len_nxt;
  digit_phase_t phase_r, phase_nxt;
  logic         neg_r, neg_nxt;
  logic [7:0]   held_byte_r, held_byte_nxt;
  logic         held_vld_r, held_vld_nxt;

  logic [7:0]   c;
  logic [31:0]  hdr_len;
  logic [31:0]  min_len;
  logic [31:0]  size;
  logic [31:0]  digit;
  logic [31:0]  mul10;
  logic [1:0]   lane;
  logic         is_dig;
  logic         is_blank;
  verdict_t     vrd;

  assign c        = beat.data_byte;
  assign hdr_len  = frame_mode ? HDR_LEN_M1 : HDR_LEN_M0;
  assign min_len  = frame_mode ? MIN_LEN_M1 : MIN_LEN_M0;
  assign is_dig   = (c >= CHR_ZERO) && (c <= CHR_NINE);
  assign is_blank = (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
  assign digit    = {24'b0, c - CHR_ZERO};
  assign mul10    = {decl_len_r[28:0], 3'b0} + {decl_len_r[30:0], 1'b0} + digit;
  assign lane     = pos_r[1:0] - 2'd2;
  assign size     = (pos_r == POS_MAX) ? POS_MAX : pos_r + 32'd1;

  // header and length field
  always_comb begin
    hdr_good_nxt = hdr_good_r;
    decl_len_nxt = decl_len_r;
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    if (pos_r == 32'd0) begin
      if (c != (frame_mode ? CHR_N : CHR_E)) begin
        hdr_good_nxt = 1'b0;
      end
    end else if (pos_r == 32'd1) begin
      if (c != (frame_mode ? CHR_H : CHR_P)) begin
        hdr_good_nxt = 1'b0;
      end
    end else if (pos_r < hdr_len) begin
      if (frame_mode) begin
        case (phase_r)
          PH_START: begin
            if (is_blank) begin
              phase_nxt = PH_START;
            end else if (c == CHR_PLUS) begin
              phase_nxt = PH_SIGN;
            end else if (c == CHR_MINUS) begin
              neg_nxt   = 1'b1;
              phase_nxt = PH_SIGN;
            end else if (is_dig) begin
              decl_len_nxt = digit;
              phase_nxt    = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_SIGN: begin
            if (is_dig) begin
              decl_len_nxt = digit;
              phase_nxt    = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (is_dig) begin
              decl_len_nxt = mul10;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end else begin
        case (lane)
          2'd0:    decl_len_nxt[7:0]   = decl_len_r[7:0]   | c;
          2'd1:    decl_len_nxt[15:8]  = decl_len_r[15:8]  | c;
          2'd2:    decl_len_nxt[23:16] = decl_len_r[23:16] | c;
          default: decl_len_nxt[31:24] = decl_len_r[31:24] | c;
        endcase
      end
    end
  end

  // verdict, first failing check wins
  always_comb begin
    if (size < min_len) begin
      vrd = VRD_SHORT;
    end else if (!hdr_good_nxt) begin
      vrd = VRD_BAD_HDR;
    end else if ((frame_mode && neg_nxt && (decl_len_nxt != '0)) ||
                 (decl_len_nxt != size)) begin
      vrd = VRD_LEN_MISMATCH;
    end else if (c != CHR_TAIL) begin
      vrd = VRD_BAD_TAIL;
    end else begin
      vrd = VRD_OK;
    end
  end

  // record towards the back end
  assign rec.pay_vld  = held_vld_r;
  assign rec.pay_byte = held_byte_r;
  assign rec.vrd_vld  = beat.last_byte;
  assign rec.verdict  = vrd;
  assign push         = acc && (held_vld_r || beat.last_byte);

  // held byte and position
  always_comb begin
    held_vld_nxt  = 1'b0;
    held_byte_nxt = held_byte_r;
    pos_nxt       = (pos_r == POS_MAX) ? POS_MAX : pos_r + 32'd1;
    if (pos_r >= hdr_len) begin
      held_vld_nxt  = 1'b1;
      held_byte_nxt = c;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      hdr_good_r <= 1'b1;
      decl_len_r <= '0;
      phase_r    <= PH_START;
      neg_r      <= 1'b0;
      held_vld_r <= 1'b0;
    end else if (acc) begin
      if (beat.last_byte) begin
        pos_r      <= '0;
        hdr_good_r <= 1'b1;
        decl_len_r <= '0;
        phase_r    <= PH_START;
        neg_r      <= 1'b0;
        held_vld_r <= 1'b0;
      end else begin
        pos_r      <= pos_nxt;
        hdr_good_r <= hdr_good_nxt;
        decl_len_r <= decl_len_nxt;
        phase_r    <= phase_nxt;
        neg_r      <= neg_nxt;
        held_vld_r <= held_vld_nxt;
      end
    end
  end

  // held payload byte
  always_ff @(posedge clk) begin
    if (acc) begin
      held_byte_r <= held_byte_nxt;
    end
  end

endmodule

@@ src/lpfc_back.sv @@
// back end: expands step records into output beats
module lpfc_back import lpfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_head_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_beat
);

  out_beat_t out_r, out_nxt;
  logic      out_vld_r;
  logic      pay_done_r, pay_done_nxt;
  logic      load;

  assign load      = head.vld && (!out_vld_r || !out_stall);
  assign out_valid = out_vld_r;
  assign out_beat  = out_r;

  // pick next beat: payload byte first, then verdict
  always_comb begin
    out_nxt      = out_r;
    pay_done_nxt = pay_done_r;
    pop          = 1'b0;
    if (load) begin
      if (head.rec.pay_vld && !pay_done_r) begin
        out_nxt.item_kind    = KIND_PAYLOAD;
        out_nxt.payload_byte = head.rec.pay_byte;
        out_nxt.verdict      = VRD_OK;
        out_nxt.frame_end    = 1'b0;
        if (head.rec.vrd_vld) begin
          pay_done_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        out_nxt.item_kind    = KIND_VERDICT;
        out_nxt.payload_byte = 8'h00;
        out_nxt.verdict      = head.rec.verdict;
        out_nxt.frame_end    = 1'b1;
        pay_done_nxt         = 1'b0;
        pop                  = 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pay_done_r <= 1'b0;
    end else begin
      pay_done_r <= pay_done_nxt;
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

@@ src/length_prefixed_frame_checker.sv @@
// top level of the length prefixed frame checker
// Accepts one frame byte per clock while in_stall is low (in_beat, last_byte on
// the final byte) and returns each payload byte one beat late, then a verdict
// beat after the last byte. Input bytes are checked by the front end and queued
// in a four-entry record queue; the output register drains one beat per clock
// while out_stall is low. A frame's last byte yields two beats (held payload
// byte and verdict), so the queue absorbs that extra beat and the input keeps
// its rate of one byte per clock. in_stall rises only when the queue is full,
// i.e. when the output side has been stalled. frame_mode may also be written
// inside a frame, with no beats still pending; each byte is read under the mode
// in force when it is accepted.
module length_prefixed_frame_checker import lpfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic        frame_mode_r;
  logic        acc;
  logic        push;
  logic        pop;
  logic        full;
  step_rec_t   rec;
  queue_head_t head;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign acc       = in_valid && !in_stall;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      frame_mode_r <= cfg_data;
    end
  end

  lpfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_mode (frame_mode_r),
    .acc        (acc),
    .beat       (in_beat),
    .push       (push),
    .rec        (rec)
  );

  lpfc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (rec),
    .full     (full),
    .pop      (pop),
    .head     (head)
  );

  lpfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule
